// ===== sv/idftbe_pkg.sv =====
// idftbe_pkg: shared defaults, command and status structs and the twiddle
// generator for the inverse dft bin evaluator
// no dependencies
package idftbe_pkg;

    localparam int MAX_POINTS_D   = 1024;
    localparam int SAMPLE_BITS_D  = 24;
    localparam int TWIDDLE_BITS_D = 18;
    localparam int BIN_BITS       = 10;
    localparam int CFG_BITS       = 4;
    localparam int LG_RESET       = 10;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint          ONE_Q30_S   = 64'sd1 <<< 30;

    // taylor term divisors for cos and sin
    localparam longint unsigned COS_DIV [13] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
        64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650};
    localparam longint unsigned SIN_DIV [13] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702};

    typedef struct packed {
        logic load;      // sample word taken
        logic req;       // bin request taken
        logic acc_clr;   // complete request: clear sums
        logic early;     // request before all samples loaded
        logic rd;        // sweep read issued
        logic round_q;
        logic mul_q;
        logic sum_y;
        logic fin;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic all_loaded;
        logic pipe_busy;
        logic out_free;
    } sts_t;

    function automatic longint to_twiddle(input longint v_in, input int twb);
        longint v;
        int     sh;
        begin
            v  = v_in;
            sh = 30 - (twb - 2);
            if (v < 0) begin
                v = 0;
            end
            if (v > ONE_Q30_S) begin
                v = ONE_Q30_S;
            end
            return (v + (64'sd1 <<< (sh - 1))) >>> sh;
        end
    endfunction

    // {cos, sin} of 2*pi*t/2^lgm, each 32 bits signed, q1.(twb-2)
    function automatic logic [63:0] twiddle_entry(input int t, input int lgm, input int twb);
        longint unsigned num, quad, rm, a, a2, tc, ts;
        longint          sc, ss, c, s, cv, sv;
        begin
            num  = longint'(t) << 2;
            quad = num >> lgm;
            rm   = num & ((64'd1 << lgm) - 64'd1);
            a    = (HALF_PI_Q30 * rm) >> lgm;
            a2   = (a * a) >> 30;
            tc   = ONE_Q30;
            ts   = a;
            sc   = ONE_Q30_S;
            ss   = longint'(a);
            for (int i = 1; i <= 13; i++) begin
                tc = ((tc * a2) >> 30) / COS_DIV[i-1];
                ts = ((ts * a2) >> 30) / SIN_DIV[i-1];
                if ((i & 1) == 1) begin
                    sc = sc - longint'(tc);
                    ss = ss - longint'(ts);
                end else begin
                    sc = sc + longint'(tc);
                    ss = ss + longint'(ts);
                end
            end
            c = to_twiddle(sc, twb);
            s = to_twiddle(ss, twb);
            case (quad[1:0])
                2'd0: begin
                    cv = c;
                    sv = s;
                end
                2'd1: begin
                    cv = -s;
                    sv = c;
                end
                2'd2: begin
                    cv = -c;
                    sv = -s;
                end
                default: begin
                    cv = s;
                    sv = -c;
                end
            endcase
            return {cv[31:0], sv[31:0]};
        end
    endfunction

endpackage

// ===== sv/idftbe_rom.sv =====
// idftbe_rom: twiddle rom, cos and sin of 2*pi*t/MAX_POINTS, registered read
// contents built at elaboration by idftbe_pkg::twiddle_entry
module idftbe_rom #(
    parameter int MAX_POINTS   = idftbe_pkg::MAX_POINTS_D,
    parameter int TWIDDLE_BITS = idftbe_pkg::TWIDDLE_BITS_D
) (
    input  logic                                  aclk,
    input  logic [$clog2(MAX_POINTS)-1:0]         addr,
    output logic signed [TWIDDLE_BITS-1:0]        cos_q,
    output logic signed [TWIDDLE_BITS-1:0]        sin_q
);
    localparam int LGM = $clog2(MAX_POINTS);

    logic [TWIDDLE_BITS-1:0] cos_tab [MAX_POINTS];
    logic [TWIDDLE_BITS-1:0] sin_tab [MAX_POINTS];

    for (genvar t = 0; t < MAX_POINTS; t++) begin : g_ent
        localparam logic [63:0] ENT = idftbe_pkg::twiddle_entry(t, LGM, TWIDDLE_BITS);
        assign cos_tab[t] = ENT[32 +: TWIDDLE_BITS];
        assign sin_tab[t] = ENT[0 +: TWIDDLE_BITS];
    end

    always_ff @(posedge aclk) begin
        cos_q <= $signed(cos_tab[addr]);
        sin_q <= $signed(sin_tab[addr]);
    end

endmodule

// ===== sv/idftbe_ctrl.sv =====
// idftbe_ctrl: controller for the bin evaluator, sequences the sample sweep
// and the join steps; uses idftbe_pkg command and status structs
module idftbe_ctrl #(
    parameter int MAX_POINTS = idftbe_pkg::MAX_POINTS_D
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_kind,
    output logic                           s_tready,
    input  idftbe_pkg::sts_t               sts,
    input  logic [$clog2(MAX_POINTS)-1:0]  nmask,
    input  logic [$clog2(MAX_POINTS)-1:0]  step2k,
    output idftbe_pkg::cmd_t               cmd,
    output logic [$clog2(MAX_POINTS)-1:0]  rd_addr,
    output logic [$clog2(MAX_POINTS)-1:0]  tw_e
);
    localparam int LGM = $clog2(MAX_POINTS);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SWEEP, ST_DRAIN, ST_RND, ST_MUL, ST_SUM, ST_FIN, ST_OUT
    } state_t;

    state_t         state_reg;
    logic           ready_reg;
    logic [LGM-1:0] j_reg;
    logic [LGM-1:0] e_reg;
    logic           take;

    assign take     = s_tvalid & ready_reg;
    assign s_tready = ready_reg;
    assign rd_addr  = j_reg;
    assign tw_e     = e_reg;

    always_comb begin
        cmd          = '0;
        cmd.load     = take & ~s_kind;
        cmd.req      = take & s_kind;
        cmd.acc_clr  = take & s_kind & sts.all_loaded;
        cmd.early    = take & s_kind & ~sts.all_loaded;
        cmd.rd       = (state_reg == ST_SWEEP);
        cmd.round_q  = (state_reg == ST_RND);
        cmd.mul_q    = (state_reg == ST_MUL);
        cmd.sum_y    = (state_reg == ST_SUM);
        cmd.fin      = (state_reg == ST_FIN);
        cmd.out_load = (state_reg == ST_OUT) & sts.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
            j_reg     <= '0;
            e_reg     <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (take && s_kind) begin
                        ready_reg <= 1'b0;
                        j_reg     <= '0;
                        e_reg     <= '0;
                        state_reg <= sts.all_loaded ? ST_SWEEP : ST_OUT;
                    end
                end
                ST_SWEEP: begin
                    if (j_reg == nmask) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        j_reg <= j_reg + 1'b1;
                        // even and odd sample of a pair share one twiddle
                        if (j_reg[0]) begin
                            e_reg <= (e_reg + step2k) & nmask;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (!sts.pipe_busy) begin
                        state_reg <= ST_RND;
                    end
                end
                ST_RND: state_reg <= ST_MUL;
                ST_MUL: state_reg <= ST_SUM;
                ST_SUM: state_reg <= ST_FIN;
                ST_FIN: state_reg <= ST_OUT;
                ST_OUT: begin
                    if (sts.out_free) begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

// ===== sv/idftbe_dp.sv =====
// idftbe_dp: datapath of the bin evaluator: length register, sample memory,
// load counter, multiply-accumulate pipe, join arithmetic and output register
// depends on idftbe_pkg and idftbe_rom
module idftbe_dp #(
    parameter int MAX_POINTS   = idftbe_pkg::MAX_POINTS_D,
    parameter int SAMPLE_BITS  = idftbe_pkg::SAMPLE_BITS_D,
    parameter int TWIDDLE_BITS = idftbe_pkg::TWIDDLE_BITS_D,
    parameter int S_W          = 64,
    parameter int M_W          = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    input  logic [idftbe_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic [S_W-1:0]                        s_tdata,
    input  idftbe_pkg::cmd_t                      cmd,
    input  logic [$clog2(MAX_POINTS)-1:0]         rd_addr,
    input  logic [$clog2(MAX_POINTS)-1:0]         tw_e,
    output idftbe_pkg::sts_t                      sts,
    output logic [$clog2(MAX_POINTS)-1:0]         nmask,
    output logic [$clog2(MAX_POINTS)-1:0]         step2k,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [M_W-1:0]                        m_tdata,
    output logic                                  m_tuser
);
    localparam int LGM   = $clog2(MAX_POINTS);
    localparam int SB    = SAMPLE_BITS;
    localparam int TW    = TWIDDLE_BITS;
    localparam int TWF   = TW - 2;
    localparam int BINB  = idftbe_pkg::BIN_BITS;
    localparam int CB    = idftbe_pkg::CFG_BITS;
    localparam int PR_W  = SB + TW;
    localparam int ACC_W = SB + TW + LGM;
    localparam int QR_W  = ACC_W + 1 - TWF;
    localparam int QP_W  = QR_W + TW;
    localparam int Y_W   = QP_W + 2;
    localparam int SH_W  = $clog2(TWF + LGM + 1);
    localparam int LG_RST_I = (idftbe_pkg::LG_RESET > LGM) ? LGM : idftbe_pkg::LG_RESET;

    localparam logic [CB-1:0]        LG_MAX   = CB'(LGM);
    localparam logic [CB-1:0]        LG_MIN   = CB'(1);
    localparam logic [CB-1:0]        LG_RST   = CB'(LG_RST_I);
    localparam logic signed [ACC_W:0] HALF_Q  = (ACC_W+1)'(1) <<< (TWF - 1);
    localparam logic signed [Y_W:0]   ONE_Y   = (Y_W+1)'(1);
    localparam logic signed [Y_W:0]   SAT_HI  = ((Y_W+1)'(1) <<< (SB - 1)) - ONE_Y;
    localparam logic signed [Y_W:0]   SAT_LO  = -SAT_HI - ONE_Y;

    // configuration and load state
    logic [CB-1:0]   lg_reg;
    logic [CB-1:0]   cfg_lg;
    logic [CB-1:0]   shamt;
    logic [LGM-1:0]  load_count_reg;
    logic            all_loaded_reg;

    // request
    logic [LGM-1:0]       k_reg;
    logic                 inc_reg;
    logic [LGM+BINB-1:0]  bin_wide;
    logic [LGM+BINB-1:0]  k_wide;

    // memory and rom
    logic [2*SB-1:0]        mem [MAX_POINTS];
    logic [2*SB-1:0]        ram_q_reg;
    logic [LGM-1:0]         rom_addr;
    logic signed [TW-1:0]   tw_c;
    logic signed [TW-1:0]   tw_s;
    logic signed [SB-1:0]   x_re;
    logic signed [SB-1:0]   x_im;

    // mac pipe
    logic                     v1_reg, v2_reg, par1_reg, par2_reg;
    logic signed [PR_W-1:0]   m_rc_reg, m_is_reg, m_rs_reg, m_ic_reg;
    logic signed [ACC_W-1:0]  t_re, t_im;
    logic signed [ACC_W-1:0]  p_re_reg, p_im_reg, q_re_reg, q_im_reg;

    // join
    logic signed [ACC_W:0]   q_re_h, q_im_h;
    logic signed [ACC_W:0]   q_re_s, q_im_s;
    logic signed [QR_W-1:0]  qr_re_reg, qr_im_reg;
    logic signed [QP_W-1:0]  mq_rc_reg, mq_is_reg, mq_rs_reg, mq_ic_reg;
    logic signed [Y_W-1:0]   y_re_reg, y_im_reg;
    logic [SH_W-1:0]         fsh;
    logic signed [Y_W:0]     y_half;
    logic signed [Y_W:0]     y_re_r, y_im_r, y_re_s, y_im_s, y_re_t, y_im_t;
    logic signed [SB-1:0]    res_re_reg, res_im_reg;

    // output
    logic            m_tvalid_reg;
    logic [M_W-1:0]  m_tdata_reg;
    logic            m_tuser_reg;

    // length register, saturated into the supported range
    always_comb begin
        if (cfg_data < LG_MIN) begin
            cfg_lg = LG_MIN;
        end else if (cfg_data > LG_MAX) begin
            cfg_lg = LG_MAX;
        end else begin
            cfg_lg = cfg_data;
        end
    end

    assign shamt    = LG_MAX - lg_reg;
    assign nmask    = {LGM{1'b1}} >> shamt;
    assign step2k   = (k_reg << 1) & nmask;
    assign bin_wide = {{LGM{1'b0}}, s_tdata[2*SB +: BINB]};
    assign k_wide   = {{BINB{1'b0}}, k_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lg_reg         <= LG_RST;
            load_count_reg <= '0;
            all_loaded_reg <= 1'b0;
        end else if (cfg_valid) begin
            lg_reg         <= cfg_lg;
            load_count_reg <= '0;
            all_loaded_reg <= 1'b0;
        end else if (cmd.load) begin
            if (load_count_reg == nmask) begin
                load_count_reg <= '0;
                all_loaded_reg <= 1'b1;
            end else begin
                load_count_reg <= load_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mem[load_count_reg] <= s_tdata[2*SB-1:0];
        end
        if (cmd.rd) begin
            ram_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.req) begin
            k_reg   <= bin_wide[LGM-1:0] & nmask;
            inc_reg <= ~all_loaded_reg;
        end
    end

    // sweep uses the pair exponent, otherwise the rom holds w^k for the join
    assign rom_addr = cmd.rd ? (tw_e << shamt) : (k_reg << shamt);

    idftbe_rom #(
        .MAX_POINTS   (MAX_POINTS),
        .TWIDDLE_BITS (TWIDDLE_BITS)
    ) u_rom (
        .aclk  (aclk),
        .addr  (rom_addr),
        .cos_q (tw_c),
        .sin_q (tw_s)
    );

    assign x_re = $signed(ram_q_reg[SB-1:0]);
    assign x_im = $signed(ram_q_reg[2*SB-1:SB]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.rd;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        par1_reg <= rd_addr[0];
        par2_reg <= par1_reg;
        if (v1_reg) begin
            m_rc_reg <= x_re * tw_c;
            m_is_reg <= x_im * tw_s;
            m_rs_reg <= x_re * tw_s;
            m_ic_reg <= x_im * tw_c;
        end
    end

    assign t_re = ACC_W'(m_rc_reg) - ACC_W'(m_is_reg);
    assign t_im = ACC_W'(m_rs_reg) + ACC_W'(m_ic_reg);

    // even samples sum into p, odd samples into q
    always_ff @(posedge aclk) begin
        if (cmd.acc_clr) begin
            p_re_reg <= '0;
            p_im_reg <= '0;
            q_re_reg <= '0;
            q_im_reg <= '0;
        end else if (v2_reg) begin
            if (par2_reg) begin
                q_re_reg <= q_re_reg + t_re;
                q_im_reg <= q_im_reg + t_im;
            end else begin
                p_re_reg <= p_re_reg + t_re;
                p_im_reg <= p_im_reg + t_im;
            end
        end
    end

    assign q_re_h = (ACC_W+1)'(q_re_reg) + HALF_Q;
    assign q_im_h = (ACC_W+1)'(q_im_reg) + HALF_Q;
    assign q_re_s = q_re_h >>> TWF;
    assign q_im_s = q_im_h >>> TWF;

    // final scaling by 1/n with rounding half up
    assign fsh    = SH_W'(TWF) + SH_W'(lg_reg);
    assign y_half = ONE_Y << (fsh - 1'b1);
    assign y_re_r = (Y_W+1)'(y_re_reg) + y_half;
    assign y_im_r = (Y_W+1)'(y_im_reg) + y_half;
    assign y_re_s = y_re_r >>> fsh;
    assign y_im_s = y_im_r >>> fsh;

    always_comb begin
        if (y_re_s > SAT_HI) begin
            y_re_t = SAT_HI;
        end else if (y_re_s < SAT_LO) begin
            y_re_t = SAT_LO;
        end else begin
            y_re_t = y_re_s;
        end
        if (y_im_s > SAT_HI) begin
            y_im_t = SAT_HI;
        end else if (y_im_s < SAT_LO) begin
            y_im_t = SAT_LO;
        end else begin
            y_im_t = y_im_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.round_q) begin
            qr_re_reg <= QR_W'(q_re_s);
            qr_im_reg <= QR_W'(q_im_s);
        end
        if (cmd.mul_q) begin
            mq_rc_reg <= qr_re_reg * tw_c;
            mq_is_reg <= qr_im_reg * tw_s;
            mq_rs_reg <= qr_re_reg * tw_s;
            mq_ic_reg <= qr_im_reg * tw_c;
        end
        if (cmd.sum_y) begin
            y_re_reg <= Y_W'(p_re_reg) + Y_W'(mq_rc_reg) - Y_W'(mq_is_reg);
            y_im_reg <= Y_W'(p_im_reg) + Y_W'(mq_rs_reg) + Y_W'(mq_ic_reg);
        end
        if (cmd.early) begin
            res_re_reg <= '0;
            res_im_reg <= '0;
        end else if (cmd.fin) begin
            res_re_reg <= SB'(y_re_t);
            res_im_reg <= SB'(y_im_t);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= M_W'({res_im_reg, res_re_reg, k_wide[BINB-1:0]});
            m_tuser_reg <= inc_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign sts.all_loaded = all_loaded_reg;
    assign sts.pipe_busy  = v1_reg | v2_reg;
    assign sts.out_free   = ~m_tvalid_reg | m_tready;

endmodule

// ===== sv/inverse_dft_bin_evaluator_unit.sv =====
// inverse dft bin evaluator, top level: controller and datapath
// depends on idftbe_pkg, idftbe_ctrl, idftbe_dp (with idftbe_rom)
//
// Usage: the input stream carries sample words (tuser low) and bin requests
// (tuser high). Samples fill entries 0..n-1 in turn, n = 2^points_log2; after
// n loads the set counts as complete and later loads overwrite from entry 0.
// A request returns one word: bin k = bin_index mod n of the inverse dft,
// divided by n, rounded and saturated. A request made before the set is
// complete returns zeros with tuser high once the output register is free.
// The cfg channel writes points_log2 (always ready); a write restarts loading.
// Throughput: a sample word is taken every cycle while no request is busy. A
// complete request then does one sample memory read and one complex
// multiply-accumulate per cycle; s_tready stays low until the result is shown.
// A finished result waits in the output register while m_tready is low; the
// block keeps taking sample words and holds a new result until that register
// frees. Reset empties the output, sets points_log2 to 10 (limited to the
// supported size) and marks the set incomplete; the sample memory is not cleared.
module inverse_dft_bin_evaluator_unit #(
    parameter int MAX_POINTS   = idftbe_pkg::MAX_POINTS_D,
    parameter int SAMPLE_BITS  = idftbe_pkg::SAMPLE_BITS_D,
    parameter int TWIDDLE_BITS = idftbe_pkg::TWIDDLE_BITS_D
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // sample_re, sample_im, bin_index, zero fill
    input  logic [((2*SAMPLE_BITS+idftbe_pkg::BIN_BITS+7)/8)*8-1:0] s_tdata,
    // kind
    input  logic                                    s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // out_bin, out_re, out_im, zero fill
    output logic [((2*SAMPLE_BITS+idftbe_pkg::BIN_BITS+7)/8)*8-1:0] m_tdata,
    // incomplete
    output logic                                    m_tuser,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [idftbe_pkg::CFG_BITS-1:0]         cfg_data
);
    localparam int LGM = $clog2(MAX_POINTS);
    localparam int D_W = ((2*SAMPLE_BITS + idftbe_pkg::BIN_BITS + 7) / 8) * 8;

    idftbe_pkg::cmd_t cmd;
    idftbe_pkg::sts_t sts;
    logic [LGM-1:0]   nmask;
    logic [LGM-1:0]   step2k;
    logic [LGM-1:0]   rd_addr;
    logic [LGM-1:0]   tw_e;

    assign cfg_ready = 1'b1;

    idftbe_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .nmask    (nmask),
        .step2k   (step2k),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .tw_e     (tw_e)
    );

    idftbe_dp #(
        .MAX_POINTS   (MAX_POINTS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .TWIDDLE_BITS (TWIDDLE_BITS),
        .S_W          (D_W),
        .M_W          (D_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .tw_e      (tw_e),
        .sts       (sts),
        .nmask     (nmask),
        .step2k    (step2k),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== sv/idftbe_chk.sv =====
// idftbe_chk: port-level checks for the inverse dft bin evaluator
// bound to inverse_dft_bin_evaluator_unit; uses idftbe_pkg constants
module idftbe_chk #(
    parameter int SAMPLE_BITS = idftbe_pkg::SAMPLE_BITS_D
) (
    input logic                                    aclk,
    input logic                                    aresetn,
    input logic                                    s_tvalid,
    input logic                                    s_tready,
    input logic                                    s_tuser,
    input logic                                    m_tvalid,
    input logic                                    m_tready,
    input logic [((2*SAMPLE_BITS+idftbe_pkg::BIN_BITS+7)/8)*8-1:0] m_tdata,
    input logic                                    m_tuser
);
    localparam int BINB = idftbe_pkg::BIN_BITS;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output not empty or input not ready after reset");

    // a request occupies the block, a sample word does not
    a_req_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input still ready after a bin request");

    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser |=> s_tready)
        else $error("input dropped ready after a sample word");

    a_early_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[2*SAMPLE_BITS+BINB-1:BINB] == '0)
        else $error("incomplete result carries nonzero data");

endmodule

bind inverse_dft_bin_evaluator_unit idftbe_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_idftbe_chk (.*);

// ===== test/inverse_dft_bin_evaluator_unit_tb.sv =====
// inverse_dft_bin_evaluator_unit_tb: self-checking bench for the inverse dft bin
// evaluator, sample and bin request words checked against an in-bench model
// depends on idftbe_pkg and inverse_dft_bin_evaluator_unit
module inverse_dft_bin_evaluator_unit_tb;
    import idftbe_pkg::*;

    localparam int SB            = SAMPLE_BITS_D;
    localparam int DW            = ((2*SB+BIN_BITS+7)/8)*8;
    localparam int NMAX          = MAX_POINTS_D;
    localparam int LG_MAX        = $clog2(MAX_POINTS_D);
    localparam int TW_FRAC       = TWIDDLE_BITS_D - 2;
    localparam int BIN_TOP       = (1 << BIN_BITS) - 1;
    localparam int RANDOM_WORDS  = 555;
    localparam int CALM_FROM     = 460;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = NMAX + 16;
    localparam int LONG_HOLD     = 400;
    localparam longint CYCLE_LIMIT = 5000000;
    localparam logic signed [SB-1:0] SAMPLE_TOP    = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAMPLE_BOTTOM = {1'b1, {(SB-1){1'b0}}};

    typedef enum logic {
        WORD_SAMPLE  = 1'b0,
        WORD_REQUEST = 1'b1
    } word_kind_t;

    typedef struct {
        word_kind_t           kind;
        logic signed [SB-1:0] re;
        logic signed [SB-1:0] im;
        logic [BIN_BITS-1:0]  bin;
    } in_word_t;

    typedef struct {
        logic [BIN_BITS-1:0]  bin;
        logic signed [SB-1:0] re;
        logic signed [SB-1:0] im;
        logic                 incomplete;
    } bin_word_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [DW-1:0]       s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [DW-1:0]       m_tdata;
    logic                m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_BITS-1:0] cfg_data  = '0;

    inverse_dft_bin_evaluator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // model state
    longint               tw_cos [NMAX];
    longint               tw_sin [NMAX];
    logic signed [SB-1:0] set_re [NMAX];
    logic signed [SB-1:0] set_im [NMAX];
    int                   fill_pos     = 0;
    logic                 set_complete = 1'b0;
    logic [CFG_BITS-1:0]  length_reg   = CFG_BITS'(LG_RESET);

    in_word_t  words_to_send [$];
    bin_word_t bins_due [$];
    int        words_queued = 0;
    int        errors       = 0;
    longint    cycles       = 0;
    logic      jitter       = 1'b0;
    logic      calm         = 1'b0;
    logic      hold_armed   = 1'b0;
    logic      hold_spent   = 1'b0;
    int        hold_left    = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic longint tw_from_q30(input longint v);
        longint x = v;
        if (x < 0) x = 0;
        if (x > ONE_Q30_S) x = ONE_Q30_S;
        return (x + (64'sd1 <<< (29 - TW_FRAC))) >>> (30 - TW_FRAC);
    endfunction

    // first-quadrant taylor series in unsigned q30, rotated into place
    task automatic build_twiddles();
        longint unsigned num, quad, rm, a, a2, tc, ts;
        longint          sc, ss, c, s;
        for (int t = 0; t < NMAX; t++) begin
            num  = longint'(t) << 2;
            quad = num / NMAX;
            rm   = num % NMAX;
            a    = HALF_PI_Q30 * rm / NMAX;
            a2   = (a * a) >> 30;
            tc   = ONE_Q30;
            ts   = a;
            sc   = ONE_Q30_S;
            ss   = $signed(a);
            for (longint unsigned i = 1; i <= 13; i++) begin
                tc = ((tc * a2) >> 30) / ((2 * i - 1) * (2 * i));
                ts = ((ts * a2) >> 30) / ((2 * i) * (2 * i + 1));
                if (i[0]) begin
                    sc = sc - $signed(tc);
                    ss = ss - $signed(ts);
                end else begin
                    sc = sc + $signed(tc);
                    ss = ss + $signed(ts);
                end
            end
            c = tw_from_q30(sc);
            s = tw_from_q30(ss);
            case (quad[1:0])
                2'd0: begin
                    tw_cos[t] = c;
                    tw_sin[t] = s;
                end
                2'd1: begin
                    tw_cos[t] = -s;
                    tw_sin[t] = c;
                end
                2'd2: begin
                    tw_cos[t] = -c;
                    tw_sin[t] = -s;
                end
                default: begin
                    tw_cos[t] = s;
                    tw_sin[t] = -c;
                end
            endcase
        end
    endtask

    // floor(v / 2^sh + 1/2)
    function automatic longint round_shift(input longint v, input int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [SB-1:0] clip_sample(input longint v);
        longint r = v;
        if (r > SAMPLE_TOP) r = SAMPLE_TOP;
        if (r < SAMPLE_BOTTOM) r = SAMPLE_BOTTOM;
        return r[SB-1:0];
    endfunction

    function automatic int length_in_use();
        if (length_reg < 1) return 1;
        if (length_reg > LG_MAX) return LG_MAX;
        return int'(length_reg);
    endfunction

    // updates the sample set, or works out the bin word that a request returns
    task automatic evaluate_word(input in_word_t w);
        int        lg, n, stride, k, e, step, t;
        longint    pr, pim, qr, qim, ar, ai, br, bi, qrr, qir, yr, yi;
        bin_word_t r;
        lg     = length_in_use();
        n      = 1 << lg;
        stride = NMAX >> lg;
        if (w.kind == WORD_SAMPLE) begin
            t         = fill_pos & (n - 1);
            set_re[t] = w.re;
            set_im[t] = w.im;
            fill_pos  = t + 1;
            if (fill_pos >= n) begin
                fill_pos     = 0;
                set_complete = 1'b1;
            end
        end else begin
            k            = int'(w.bin) & (n - 1);
            r.bin        = k[BIN_BITS-1:0];
            r.re         = '0;
            r.im         = '0;
            r.incomplete = !set_complete;
            if (set_complete) begin
                pr   = 0;
                pim  = 0;
                qr   = 0;
                qim  = 0;
                e    = 0;
                step = (2 * k) & (n - 1);
                // even and odd halves share the exponent walk
                for (int m = 0; m < n / 2; m++) begin
                    t   = (e * stride) & (NMAX - 1);
                    ar  = set_re[2*m];
                    ai  = set_im[2*m];
                    br  = set_re[2*m+1];
                    bi  = set_im[2*m+1];
                    pr  = pr + ar * tw_cos[t] - ai * tw_sin[t];
                    pim = pim + ar * tw_sin[t] + ai * tw_cos[t];
                    qr  = qr + br * tw_cos[t] - bi * tw_sin[t];
                    qim = qim + br * tw_sin[t] + bi * tw_cos[t];
                    e   = (e + step) & (n - 1);
                end
                qrr  = round_shift(qr, TW_FRAC);
                qir  = round_shift(qim, TW_FRAC);
                t    = (k * stride) & (NMAX - 1);
                yr   = pr + qrr * tw_cos[t] - qir * tw_sin[t];
                yi   = pim + qrr * tw_sin[t] + qir * tw_cos[t];
                r.re = clip_sample(round_shift(yr, TW_FRAC + lg));
                r.im = clip_sample(round_shift(yi, TW_FRAC + lg));
            end
            bins_due.push_back(r);
        end
    endtask

    task automatic check_field(input string what, input longint want, input longint got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // driver: one word on the slave side at a time, random gaps between words
    in_word_t on_bus;
    int       tx_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                evaluate_word(on_bus);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    s_tvalid <= 1'b0;
                    tx_gap--;
                end else if (jitter && $urandom_range(0, 5) == 0) begin
                    s_tvalid <= 1'b0;
                    tx_gap = $urandom_range(0, 2);
                end else if (words_to_send.size() > 0) begin
                    on_bus = words_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= on_bus.kind;
                    s_tdata  <= DW'({on_bus.bin, on_bus.im, on_bus.re});
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares every result word with the oldest bin due
    bin_word_t seen, want;
    int        rx_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.bin        = m_tdata[BIN_BITS-1:0];
                seen.re         = m_tdata[BIN_BITS +: SB];
                seen.im         = m_tdata[BIN_BITS+SB +: SB];
                seen.incomplete = m_tuser;
                if (bins_due.size() == 0) begin
                    $display("%0t: result word with nothing due, expected none, %s",
                             $time, $sformatf("got bin %0d re %0d im %0d",
                                              seen.bin, seen.re, seen.im));
                    errors++;
                end else begin
                    want = bins_due.pop_front();
                    check_field("out_bin", longint'(want.bin), longint'(seen.bin));
                    check_field("out_re", longint'(want.re), longint'(seen.re));
                    check_field("out_im", longint'(want.im), longint'(seen.im));
                    check_field("incomplete", longint'(want.incomplete),
                                longint'(seen.incomplete));
                end
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                m_tready <= 1'b0;
                rx_gap--;
            end else if (jitter && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                rx_gap = $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // long receiver hold-off, started by the first result of the pressure phase
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left  <= 0;
            hold_spent <= 1'b0;
        end else if (hold_armed && !hold_spent && m_tvalid) begin
            hold_left  <= LONG_HOLD;
            hold_spent <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic signed [SB-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_TOP;
            1:       return SAMPLE_BOTTOM;
            2:       return '0;
            3:       return '1;
            default: return SB'($urandom());
        endcase
    endfunction

    task automatic queue_word(input word_kind_t kind, input logic signed [SB-1:0] re,
                              input logic signed [SB-1:0] im, input logic [BIN_BITS-1:0] bin);
        in_word_t w;
        w.kind = kind;
        w.re   = re;
        w.im   = im;
        w.bin  = bin;
        words_to_send.push_back(w);
        words_queued++;
    endtask

    task automatic queue_sample();
        queue_word(WORD_SAMPLE, pick_sample(), pick_sample(), BIN_BITS'($urandom()));
    endtask

    task automatic queue_request(input int bin);
        queue_word(WORD_REQUEST, pick_sample(), pick_sample(), bin[BIN_BITS-1:0]);
    endtask

    task automatic settle(input int extra);
        @(posedge aclk);
        while (words_to_send.size() != 0 || s_tvalid || bins_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (extra) @(posedge aclk);
    endtask

    // only once the block has gone quiet
    task automatic write_length(input int v);
        settle(SETTLE_CYCLES);
        cfg_data  <= v[CFG_BITS-1:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        length_reg   = v[CFG_BITS-1:0];
        fill_pos     = 0;
        set_complete = 1'b0;
        jitter       = !calm && ($urandom_range(0, 3) != 0);
    endtask

    // eight samples lined up against bin 1 so that the sum runs past full scale
    task automatic queue_aligned_set(input logic negate);
        longint               c, s;
        logic signed [SB-1:0] hi, lo;
        hi = negate ? SAMPLE_BOTTOM : SAMPLE_TOP;
        lo = negate ? SAMPLE_TOP : SAMPLE_BOTTOM;
        for (int j = 0; j < 8; j++) begin
            c = tw_cos[j * (NMAX / 8)];
            s = tw_sin[j * (NMAX / 8)];
            queue_word(WORD_SAMPLE, (c > 0) ? hi : ((c < 0) ? lo : '0),
                       (s > 0) ? lo : ((s < 0) ? hi : '0), BIN_BITS'($urandom()));
        end
        queue_request(1);
    endtask

    task automatic queue_random_phase();
        int pick, lg_w, n;
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
            lg_w = $urandom_range(1, 5);
        end else if (pick < 17) begin
            lg_w = $urandom_range(6, 8);
        end else begin
            lg_w = $urandom_range(0, 15);
        end
        write_length(lg_w);
        n = 1 << length_in_use();
        if (n <= 256 && $urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 2) == 0) begin
                queue_request($urandom_range(0, BIN_TOP));
            end
            repeat (n) queue_sample();
            repeat ($urandom_range(2, 8)) begin
                if ($urandom_range(0, 1) == 0) begin
                    queue_request($urandom_range(0, BIN_TOP));
                end else begin
                    queue_sample();
                end
            end
        end else begin
            // short run of words: requests stay incomplete unless the set fills, and the next write drops it
            repeat ($urandom_range(2, 6)) begin
                if ($urandom_range(0, 2) == 0) begin
                    queue_request($urandom_range(0, BIN_TOP));
                end else begin
                    queue_sample();
                end
            end
        end
    endtask

    initial begin
        int   base, progress;
        logic full_done;
        build_twiddles();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset length, nothing loaded yet
        queue_request(0);
        queue_sample();
        queue_request(BIN_TOP);

        // below range saturates to two points
        write_length(0);
        queue_word(WORD_SAMPLE, SAMPLE_TOP, SAMPLE_TOP, BIN_BITS'($urandom()));
        queue_request(1);
        queue_word(WORD_SAMPLE, SAMPLE_BOTTOM, SAMPLE_BOTTOM, BIN_BITS'($urandom()));
        queue_request(0);
        queue_request(BIN_TOP);

        // saturation both ways, second set overwrites the first
        write_length(3);
        queue_aligned_set(1'b0);
        queue_aligned_set(1'b1);

        base      = words_queued;
        full_done = 1'b0;
        while (words_queued - base < RANDOM_WORDS) begin
            progress = words_queued - base;
            calm     = (progress >= CALM_FROM);
            if (!full_done && progress >= 150) begin
                // above range saturates to the largest length, set left partial
                write_length(15);
                repeat (6) queue_sample();
                queue_request(0);
                queue_request(BIN_TOP);
                queue_request($urandom_range(0, BIN_TOP));
                full_done = 1'b1;
            end else if (!hold_armed && progress >= 300) begin
                write_length(2);
                hold_armed = 1'b1;
                repeat (4) queue_sample();
                repeat (24) queue_request($urandom_range(0, BIN_TOP));
            end else begin
                queue_random_phase();
            end
        end

        settle(DRAIN_CYCLES);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
